/* src/onbe_pkg.sv */
package onbe_pkg;

   // Fixed field widths of the block.
   localparam int IN_W       = 16;
   localparam int OUT_W      = 20;
   localparam int ALB_W      = 16;
   localparam int COEF_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Angles are Q30 values in [0, 1.0], so they need 31 bits.
   localparam int ANG_W = 31;
   // Every divider produces this many quotient bits, one per stage.
   localparam int QUO_W = 31;

   localparam logic [ANG_W-1:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [ANG_W-1:0] EPS_Q30    = 31'd107374;
   localparam logic [31:0]      INV_PI_Q32 = 32'd1367130551;
   localparam logic [OUT_W-1:0] OUT_MAX    = 20'hF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ALBEDO_RED   = 3'd0,
      REG_ALBEDO_GREEN = 3'd1,
      REG_ALBEDO_BLUE  = 3'd2,
      REG_COEF_A       = 3'd3,
      REG_COEF_B       = 3'd4
   } csr_reg_type;

endpackage

/* src/onbe_div_pipe.sv */
module onbe_div_pipe #(
   parameter int NUM_W = 61,
   parameter int DEN_W = 31
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic [onbe_pkg::QUO_W-1:0] quo
);

   localparam int QW = onbe_pkg::QUO_W;
   localparam int W  = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

   // Restoring division, one quotient bit per stage, most significant first.
   // The caller guarantees num < den * 2^QW, so the partial remainder always fits.
   logic [W-1:0]     rem_ff [QW];
   logic [DEN_W-1:0] den_ff [QW];
   logic [QW-1:0]    quo_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_step
      logic [W-1:0]     rem_cur;
      logic [DEN_W-1:0] den_cur;
      logic [QW-1:0]    quo_cur;
      logic [W-1:0]     trial;
      logic [W-1:0]     rem_in;
      logic [QW-1:0]    quo_in;

      if (g == 0) begin : g_first
         assign rem_cur = W'(num);
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[g-1];
         assign den_cur = den_ff[g-1];
         assign quo_cur = quo_ff[g-1];
      end

      assign trial = W'(den_cur) << (QW - 1 - g);

      always_comb begin
         rem_in = rem_cur;
         quo_in = quo_cur;
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            quo_in[QW-1-g] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_in;
            den_ff[g] <= den_cur;
            quo_ff[g] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

/* src/oren_nayar_brdf_eval_unit.sv */
// Channel   Dir   Transfer content
// req_*     in    one pair of shading-frame directions (outgoing, incoming)
// rsp_*     out   red, green and blue reflectance plus the clip flag
// csr_*     in    register write: albedo per channel, A and B terms
//
// One item can be accepted in every cycle while the output queue is not full. A result
// is offered once its input has passed 2 input stages, 31 square-root stages, 1 setup
// stage, 31 divider stages and 10 multiply stages and has been written to the output
// queue. The dividers and the square root produce one bit per stage, and that sets
// the depth.
// Synchronous reset clears the valid bits and the output queue and sets CSR defaults.
// The whole pipeline moves while the two-entry output queue is not full, so a waiting
// result does not block new input until the queue fills.
module oren_nayar_brdf_eval_unit #(
   parameter int DIR_FRAC_BITS = 14,
   parameter int OUT_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // out_dir_x, out_dir_y, out_dir_z, in_dir_x, in_dir_y, in_dir_z (16 bits each)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // refl_red, refl_green, refl_blue (20 bits each), then 4 zero bits
   output logic [63:0] rsp_tdata,
   // saturated
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int IW    = onbe_pkg::IN_W;
   localparam int AGW   = onbe_pkg::ANG_W;
   localparam int QW    = onbe_pkg::QUO_W;
   localparam int OW    = onbe_pkg::OUT_W;
   // Shift that takes a direction component to Q30.
   localparam int ZSH   = 30 - DIR_FRAC_BITS;
   localparam int CW    = IW + ZSH;
   localparam int AW    = (CW > AGW) ? CW : AGW;
   localparam int TW    = (CW + 10 > AGW) ? CW + 10 : AGW;
   localparam int RSH   = 60 - 2 * DIR_FRAC_BITS;
   localparam int OSH   = 48 - OUT_FRAC_BITS;
   localparam int SQ_N  = 31;
   localparam int N_STG = 3 + SQ_N + QW + 10;
   localparam int ST_M1 = 3 + SQ_N + QW;
   localparam int ST_M3 = ST_M1 + 2;

   typedef struct packed {
      logic [60:0] v;
      logic [61:0] r;
   } sq_pair_type;

   typedef struct packed {
      logic signed [IW-1:0] ox;
      logic signed [IW-1:0] oy;
      logic signed [IW-1:0] ix;
      logic signed [IW-1:0] iy;
      logic [IW-1:0]        moz;
      logic [IW-1:0]        miz;
   } sq_side_type;

   typedef struct packed {
      logic [AGW-1:0] sin_alpha;
      logic           need_cd;
      logic           zo;
      logic           zi;
      logic [3:0]     sgn;
      logic [3:0]     big;
      logic           tan_zero;
      logic           tan_cap;
   } dv_side_type;

   function automatic logic [IW-1:0] mag16(input logic signed [IW-1:0] v);
      logic [IW-1:0] m;
      m = v[IW-1] ? IW'(-v) : IW'(v);
      return m;
   endfunction

   // One step of the bit-by-bit integer square root; step k tests bit 2^(60-2k).
   function automatic sq_pair_type sq_step(input sq_pair_type cur, input int k);
      sq_pair_type nxt;
      logic [61:0] bitv;
      logic [61:0] trial;
      bitv  = 62'(1) << (60 - 2 * k);
      trial = cur.r + bitv;
      nxt.v = cur.v;
      nxt.r = cur.r >> 1;
      if ({1'b0, cur.v} >= trial) begin
         nxt.v = cur.v - trial[60:0];
         nxt.r = (cur.r >> 1) + bitv;
      end
      return nxt;
   endfunction

   // ---------------------------------------------------------------------------
   // CSRs. The user writes only while the pipeline is empty; the block does not enforce it.
   // ---------------------------------------------------------------------------
   logic [onbe_pkg::ALB_W-1:0]  alb_ff [3];
   logic [onbe_pkg::COEF_W-1:0] coef_a_ff;
   logic [onbe_pkg::COEF_W-1:0] coef_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alb_ff[0] <= 16'd32768;
         alb_ff[1] <= 16'd32768;
         alb_ff[2] <= 16'd32768;
         coef_a_ff <= 17'd65536;
         coef_b_ff <= 17'd0;
      end else if (csr_we) begin
         case (onbe_pkg::csr_reg_type'(csr_index))
            onbe_pkg::REG_ALBEDO_RED:   alb_ff[0] <= csr_wdata[15:0];
            onbe_pkg::REG_ALBEDO_GREEN: alb_ff[1] <= csr_wdata[15:0];
            onbe_pkg::REG_ALBEDO_BLUE:  alb_ff[2] <= csr_wdata[15:0];
            onbe_pkg::REG_COEF_A:       coef_a_ff <= csr_wdata;
            onbe_pkg::REG_COEF_B:       coef_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control. Every stage advances together while the output queue has room.
   // ---------------------------------------------------------------------------
   logic [1:0]     fifo_cnt_ff;
   logic           adv;
   logic [N_STG-1:0] vld_ff;

   assign adv        = (fifo_cnt_ff != 2'd2);
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N_STG-2:0], req_tvalid};
      end
   end

   // ---------------------------------------------------------------------------
   // Input stage and radicand stage: sin^2 = 1 - z^2, moved to a Q60 radicand.
   // ---------------------------------------------------------------------------
   logic signed [IW-1:0] in_ff [6];
   logic [60:0]          rad_o_ff;
   logic [60:0]          rad_i_ff;
   sq_side_type          rad_side_ff;
   logic [IW-1:0]        moz_c;
   logic [IW-1:0]        miz_c;
   logic [31:0]          z2o_c;
   logic [31:0]          z2i_c;
   logic [60:0]          one2;
   logic [60:0]          rad_o_in;
   logic [60:0]          rad_i_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int f = 0; f < 6; f++) begin
            in_ff[f] <= req_tdata[f*IW +: IW];
         end
      end
   end

   always_comb begin
      one2     = 61'(1) << (2 * DIR_FRAC_BITS);
      moz_c    = mag16(in_ff[2]);
      miz_c    = mag16(in_ff[5]);
      z2o_c    = moz_c * moz_c;
      z2i_c    = miz_c * miz_c;
      rad_o_in = (61'(z2o_c) >= one2) ? '0 : (one2 - 61'(z2o_c)) << RSH;
      rad_i_in = (61'(z2i_c) >= one2) ? '0 : (one2 - 61'(z2i_c)) << RSH;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_o_ff    <= rad_o_in;
         rad_i_ff    <= rad_i_in;
         rad_side_ff <= '{ox: in_ff[0], oy: in_ff[1], ix: in_ff[3], iy: in_ff[4],
                          moz: moz_c, miz: miz_c};
      end
   end

   // ---------------------------------------------------------------------------
   // Square root, one result bit per stage, both directions side by side.
   // ---------------------------------------------------------------------------
   sq_pair_type sq_o_ff    [SQ_N];
   sq_pair_type sq_i_ff    [SQ_N];
   sq_side_type sq_side_ff [SQ_N];

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      sq_pair_type o_cur;
      sq_pair_type i_cur;
      sq_side_type s_cur;

      if (k == 0) begin : g_first
         assign o_cur = '{v: rad_o_ff, r: 62'd0};
         assign i_cur = '{v: rad_i_ff, r: 62'd0};
         assign s_cur = rad_side_ff;
      end else begin : g_next
         assign o_cur = sq_o_ff[k-1];
         assign i_cur = sq_i_ff[k-1];
         assign s_cur = sq_side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_o_ff[k]    <= sq_step(o_cur, k);
            sq_i_ff[k]    <= sq_step(i_cur, k);
            sq_side_ff[k] <= s_cur;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Divider setup. Azimuth cosines and sines are coordinate / sinTheta; a
   // coordinate at least as long as sinTheta gives exactly one. Alpha goes with
   // the direction of smaller |cos|, ties going to the incoming direction, and
   // tan(beta) is capped at 1024.0.
   // ---------------------------------------------------------------------------
   sq_side_type          sqs;
   logic [AGW-1:0]       so_c;
   logic [AGW-1:0]       si_c;
   logic signed [IW-1:0] crd [4];
   logic [AW-1:0]        az_a [4];
   logic [AGW-1:0]       az_den [4];
   logic [3:0]           az_big;
   logic [3:0]           az_sgn;
   logic [60:0]          az_num [4];
   logic                 sel_i;
   logic [AGW-1:0]       t_s;
   logic [CW-1:0]        t_c;
   logic [TW-1:0]        t_c10;
   logic                 tan_zero;
   logic                 tan_cap;
   logic [50:0]          tan_num;
   dv_side_type          pr_side_in;

   assign sqs  = sq_side_ff[SQ_N-1];
   assign so_c = sq_o_ff[SQ_N-1].r[AGW-1:0];
   assign si_c = sq_i_ff[SQ_N-1].r[AGW-1:0];

   always_comb begin
      crd[0] = sqs.ox;
      crd[1] = sqs.oy;
      crd[2] = sqs.ix;
      crd[3] = sqs.iy;
      for (int j = 0; j < 4; j++) begin
         az_a[j]   = AW'(mag16(crd[j])) << ZSH;
         az_den[j] = (j < 2) ? so_c : si_c;
         az_big[j] = (az_a[j] >= AW'(az_den[j]));
         az_num[j] = az_big[j] ? '0 : {az_a[j][AGW-1:0], 30'd0};
         az_sgn[j] = crd[j][IW-1];
      end

      sel_i    = (sqs.miz > sqs.moz);
      t_s      = sel_i ? si_c : so_c;
      t_c      = CW'(sel_i ? sqs.miz : sqs.moz) << ZSH;
      t_c10    = TW'(t_c) << 10;
      tan_zero = (t_c == '0) && (t_s == '0);
      tan_cap  = (t_c == '0) ? (t_s != '0) : (TW'(t_s) > t_c10);
      tan_num  = tan_cap ? '0 : {t_s, 20'd0};

      pr_side_in.sin_alpha = sel_i ? so_c : si_c;
      pr_side_in.need_cd   = (so_c > onbe_pkg::EPS_Q30) || (si_c > onbe_pkg::EPS_Q30);
      pr_side_in.zo        = (so_c == '0);
      pr_side_in.zi        = (si_c == '0);
      pr_side_in.sgn       = az_sgn;
      pr_side_in.big       = az_big;
      pr_side_in.tan_zero  = tan_zero;
      pr_side_in.tan_cap   = tan_cap;
   end

   logic [60:0]    pr_az_num_ff [4];
   logic [AGW-1:0] pr_az_den_ff [4];
   logic [50:0]    pr_tan_num_ff;
   logic [CW-1:0]  pr_tan_den_ff;
   dv_side_type    pr_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            pr_az_num_ff[j] <= az_num[j];
            pr_az_den_ff[j] <= az_den[j];
         end
         pr_tan_num_ff <= tan_num;
         pr_tan_den_ff <= t_c;
         pr_side_ff    <= pr_side_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Dividers: four azimuth terms and tan(beta), all with the same latency.
   // ---------------------------------------------------------------------------
   logic [QW-1:0] az_q [4];
   logic [QW-1:0] tan_q;
   dv_side_type   dv_side_ff [QW];

   for (genvar j = 0; j < 4; j++) begin : g_az_div
      onbe_div_pipe #(
         .NUM_W (61),
         .DEN_W (AGW)
      ) u_div (
         .clock  (clock),
         .enable (adv),
         .num    (pr_az_num_ff[j]),
         .den    (pr_az_den_ff[j]),
         .quo    (az_q[j])
      );
   end

   onbe_div_pipe #(
      .NUM_W (51),
      .DEN_W (CW)
   ) u_tan_div (
      .clock  (clock),
      .enable (adv),
      .num    (pr_tan_num_ff),
      .den    (pr_tan_den_ff),
      .quo    (tan_q)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= pr_side_ff;
         for (int i = 1; i < QW; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // M1: signed azimuth terms and the final tan(beta). A vertical direction
   // has cosPhi one and sinPhi zero.
   // ---------------------------------------------------------------------------
   dv_side_type        dvs;
   logic [AGW-1:0]     az_mag [4];
   logic signed [31:0] az_val [4];
   logic [AGW-1:0]     tanb_c;

   assign dvs = dv_side_ff[QW-1];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         az_mag[j] = dvs.big[j] ? onbe_pkg::Q30_ONE : az_q[j];
         az_val[j] = 32'({1'b0, az_mag[j]});
         if (dvs.sgn[j]) begin
            az_val[j] = -az_val[j];
         end
      end
      if (dvs.tan_zero) begin
         tanb_c = '0;
      end else if (dvs.tan_cap) begin
         tanb_c = onbe_pkg::Q30_ONE;
      end else begin
         tanb_c = tan_q;
      end
   end

   logic signed [31:0] m1_cpo_ff;
   logic signed [31:0] m1_spo_ff;
   logic signed [31:0] m1_cpi_ff;
   logic signed [31:0] m1_spi_ff;
   logic [AGW-1:0]     tanb_ff [4];
   logic [AGW-1:0]     sa_ff [3];
   logic [1:0]         ncd_ff;
   logic [8:0]         tsat_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_cpo_ff <= dvs.zo ? 32'(onbe_pkg::Q30_ONE) : az_val[0];
         m1_spo_ff <= dvs.zo ? 32'sd0 : az_val[1];
         m1_cpi_ff <= dvs.zi ? 32'(onbe_pkg::Q30_ONE) : az_val[2];
         m1_spi_ff <= dvs.zi ? 32'sd0 : az_val[3];
         tanb_ff   <= '{tanb_c, tanb_ff[0], tanb_ff[1], tanb_ff[2]};
         sa_ff     <= '{dvs.sin_alpha, sa_ff[0], sa_ff[1]};
         ncd_ff    <= {ncd_ff[0], dvs.need_cd};
         tsat_ff   <= {tsat_ff[7:0], dvs.tan_cap};
      end
   end

   // ---------------------------------------------------------------------------
   // M2: the two products of cos(phiI - phiO).
   // ---------------------------------------------------------------------------
   logic signed [63:0] pc_full;
   logic signed [63:0] ps_full;
   logic signed [61:0] m2_pc_ff;
   logic signed [61:0] m2_ps_ff;

   assign pc_full = m1_cpi_ff * m1_cpo_ff;
   assign ps_full = m1_spi_ff * m1_spo_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_pc_ff <= pc_full[61:0];
         m2_ps_ff <= ps_full[61:0];
      end
   end

   // ---------------------------------------------------------------------------
   // M3: cosDelta, clamped to [0, 1.0]; zero when both sines are tiny.
   // ---------------------------------------------------------------------------
   logic signed [62:0] cds_c;
   logic [32:0]        cds_sh;
   logic [AGW-1:0]     cd_in;
   logic [AGW-1:0]     m3_cd_ff;

   always_comb begin
      cds_c  = m2_pc_ff + m2_ps_ff;
      cds_sh = cds_c[62:30];
      cd_in  = '0;
      if (ncd_ff[1] && (cds_c > 0)) begin
         cd_in = (cds_sh > 33'(onbe_pkg::Q30_ONE)) ? onbe_pkg::Q30_ONE : cds_sh[AGW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_cd_ff <= cd_in;
      end
   end

   // ---------------------------------------------------------------------------
   // M4 to M7: cosDelta * sinAlpha * tanBeta * B, then A is added.
   // ---------------------------------------------------------------------------
   logic [61:0] t1_full;
   logic [61:0] t2_full;
   logic [57:0] g_full;
   logic [30:0] m4_t1_ff;
   logic [40:0] m5_t2_ff;
   logic [27:0] m6_g_ff;
   logic [28:0] m7_sum_ff;

   assign t1_full = m3_cd_ff * sa_ff[2];
   assign t2_full = m4_t1_ff * tanb_ff[3];
   assign g_full  = coef_b_ff * m5_t2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m4_t1_ff  <= t1_full[60:30];
         m5_t2_ff  <= t2_full[60:20];
         m6_g_ff   <= g_full[57:30];
         m7_sum_ff <= 29'(coef_a_ff) + 29'(m6_g_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // M8 to M10: albedo, 1/pi, output scaling and saturation per channel.
   // ---------------------------------------------------------------------------
   logic [44:0]   p_full [3];
   logic [60:0]   q_full [3];
   logic [28:0]   m8_p_ff [3];
   logic [60:0]   m9_q_ff [3];
   logic [OW-1:0] m10_refl_ff [3];
   logic          m10_sat_ff;
   logic [2:0]    ch_sat;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         p_full[c] = alb_ff[c] * m7_sum_ff;
         q_full[c] = m8_p_ff[c] * onbe_pkg::INV_PI_Q32;
         ch_sat[c] = (m9_q_ff[c] > 61'(onbe_pkg::OUT_MAX));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            m8_p_ff[c]     <= p_full[c][44:16];
            m9_q_ff[c]     <= q_full[c] >> OSH;
            m10_refl_ff[c] <= ch_sat[c] ? onbe_pkg::OUT_MAX : m9_q_ff[c][OW-1:0];
         end
         m10_sat_ff <= tsat_ff[8] | (|ch_sat);
      end
   end

   // ---------------------------------------------------------------------------
   // Two-entry output queue. It decouples the result side from the pipeline.
   // ---------------------------------------------------------------------------
   logic [60:0] fifo_ff [2];
   logic        fifo_wp_ff;
   logic        fifo_rp_ff;
   logic        push;
   logic        pop;
   logic [60:0] head;

   assign push       = adv & vld_ff[N_STG-1];
   assign rsp_tvalid = (fifo_cnt_ff != 2'd0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign head       = fifo_ff[fifo_rp_ff];
   assign rsp_tdata  = {4'd0, head[59:0]};
   assign rsp_tuser  = head[60];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[fifo_wp_ff] <= {m10_sat_ff, m10_refl_ff[2], m10_refl_ff[1], m10_refl_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wp_ff  <= 1'b0;
         fifo_rp_ff  <= 1'b0;
         fifo_cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            fifo_wp_ff <= ~fifo_wp_ff;
         end
         if (pop) begin
            fifo_rp_ff <= ~fifo_rp_ff;
         end
         case ({push, pop})
            2'b10:   fifo_cnt_ff <= fifo_cnt_ff + 2'd1;
            2'b01:   fifo_cnt_ff <= fifo_cnt_ff - 2'd1;
            default: fifo_cnt_ff <= fifo_cnt_ff;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_fifo_bound : assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   a_cd_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_M3] |-> (m3_cd_ff <= onbe_pkg::Q30_ONE))
      else $error("cosDelta above one");

   a_tan_cap : assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_M1] |-> (tanb_ff[0] <= onbe_pkg::Q30_ONE))
      else $error("tan(beta) above its cap");
`endif

endmodule

/* verif/onbe_checker.sv */
module onbe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [onbe_pkg::OUT_W-1:0] red;
      logic [onbe_pkg::OUT_W-1:0] green;
      logic [onbe_pkg::OUT_W-1:0] blue;
      logic                       sat;
   } refl_type;

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned TAN_CAP = 64'd1 << 30;

   logic [onbe_pkg::ALB_W-1:0]  alb_r, alb_g, alb_b;
   logic [onbe_pkg::COEF_W-1:0] coef_a, coef_b;
   refl_type                    refl_q[$];

   function automatic longint unsigned abs16(logic signed [15:0] v);
      longint s;
      s = v;
      return s < 0 ? longint'(-s) : longint'(s);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Sine of the polar angle in Q30; a component at or above 1.0 gives zero.
   function automatic longint unsigned sin_theta_q30(logic signed [15:0] z);
      longint unsigned one2, z2, s2;
      one2 = 64'd1 << 28;
      z2   = abs16(z) * abs16(z);
      s2   = z2 >= one2 ? 0 : one2 - z2;
      return int_sqrt(s2 << 32);
   endfunction

   // Azimuth cosine or sine: coordinate over sinTheta, clamped to one.
   function automatic longint azim_q30(logic signed [15:0] c, longint unsigned s);
      longint unsigned a, r;
      a = abs16(c) << 16;
      r = a >= s ? ONE_Q30 : (a << 30) / s;
      return c < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned tan_beta_q20(longint unsigned s, longint unsigned c,
                                                    inout logic sat);
      if (c == 0) begin
         if (s == 0) return 0;
         sat = 1'b1;
         return TAN_CAP;
      end
      if (s > 1024 * c) begin
         sat = 1'b1;
         return TAN_CAP;
      end
      return (s << 20) / c;
   endfunction

   function automatic logic [onbe_pkg::OUT_W-1:0] scale_channel(longint unsigned alb,
                                                      longint unsigned term, inout logic sat);
      longint unsigned p16, q32, o;
      p16 = (alb * term) >> 16;
      q32 = (p16 * 64'(onbe_pkg::INV_PI_Q32)) >> 16;
      o   = q32 >> 16;
      if (o > 64'(onbe_pkg::OUT_MAX)) begin
         sat = 1'b1;
         return onbe_pkg::OUT_MAX;
      end
      return o[onbe_pkg::OUT_W-1:0];
   endfunction

   function automatic refl_type predict_refl(logic [95:0] d);
      logic signed [15:0] ox, oy, oz, ix, iy, iz;
      longint unsigned    so, si, cos_delta, co, ci, sin_alpha, tanb, t1, t2, g, term;
      longint             cpo, spo, cpi, spi, dot;
      logic               sat;
      refl_type           r;
      {iz, iy, ix, oz, oy, ox} = d;
      sat       = 1'b0;
      so        = sin_theta_q30(oz);
      si        = sin_theta_q30(iz);
      cos_delta = 0;
      // With both directions along the normal the azimuth is meaningless.
      if (so > 64'(onbe_pkg::EPS_Q30) || si > 64'(onbe_pkg::EPS_Q30)) begin
         cpo = ONE_Q30; spo = 0; cpi = ONE_Q30; spi = 0;
         if (so != 0) begin
            cpo = azim_q30(ox, so);
            spo = azim_q30(oy, so);
         end
         if (si != 0) begin
            cpi = azim_q30(ix, si);
            spi = azim_q30(iy, si);
         end
         dot = cpi * cpo + spi * spo;
         if (dot > 0) begin
            cos_delta = longint'(dot) >> 30;
            if (cos_delta > ONE_Q30) cos_delta = ONE_Q30;
         end
      end
      co = abs16(oz) << 16;
      ci = abs16(iz) << 16;
      // Equal cosines take alpha from the incoming direction.
      if (abs16(iz) > abs16(oz)) begin
         sin_alpha = so;
         tanb      = tan_beta_q20(si, ci, sat);
      end else begin
         sin_alpha = si;
         tanb      = tan_beta_q20(so, co, sat);
      end
      t1   = (cos_delta * sin_alpha) >> 30;
      t2   = (t1 * tanb) >> 20;
      g    = (longint'(coef_b) * t2) >> 30;
      term = longint'(coef_a) + g;
      r.red   = scale_channel(alb_r, term, sat);
      r.green = scale_channel(alb_g, term, sat);
      r.blue  = scale_channel(alb_b, term, sat);
      r.sat   = sat;
      return r;
   endfunction

   task automatic report(string field, longint unsigned want, longint unsigned got);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      refl_type want;
      if (reset) begin
         alb_r  <= 16'd32768;
         alb_g  <= 16'd32768;
         alb_b  <= 16'd32768;
         coef_a <= 17'd65536;
         coef_b <= 17'd0;
         refl_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               onbe_pkg::REG_ALBEDO_RED:   alb_r  <= csr_wdata[onbe_pkg::ALB_W-1:0];
               onbe_pkg::REG_ALBEDO_GREEN: alb_g  <= csr_wdata[onbe_pkg::ALB_W-1:0];
               onbe_pkg::REG_ALBEDO_BLUE:  alb_b  <= csr_wdata[onbe_pkg::ALB_W-1:0];
               onbe_pkg::REG_COEF_A:       coef_a <= csr_wdata;
               onbe_pkg::REG_COEF_B:       coef_b <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) refl_q.push_back(predict_refl(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (refl_q.size() == 0) begin
               $display("%0t: result transfer with nothing outstanding", $realtime);
               errors++;
            end else begin
               want = refl_q.pop_front();
               if (rsp_tdata[19:0] !== want.red)    report("refl_red", want.red, rsp_tdata[19:0]);
               if (rsp_tdata[39:20] !== want.green)
                  report("refl_green", want.green, rsp_tdata[39:20]);
               if (rsp_tdata[59:40] !== want.blue)
                  report("refl_blue", want.blue, rsp_tdata[59:40]);
               if (rsp_tuser[0] !== want.sat)      report("saturated", want.sat, rsp_tuser[0]);
            end
         end
      end
      pending = refl_q.size();
   end

endmodule

/* verif/tb_oren_nayar_brdf_eval_unit.sv */
module tb_oren_nayar_brdf_eval_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [16:0] csr_wdata;
   int          errors;
   int          pending;

   // When set, neither side inserts idle cycles.
   bit          steady;
   // A request for one long receiver hold-off; the receiver clears it when done.
   bit          hold_rsp;

   oren_nayar_brdf_eval_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   onbe_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   // A 4 ns clock.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Safety net: the slowest correct run finishes far below this.
   initial begin
      #4ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side. The receiver stalls in random bursts unless the run is in its
   // steady part. A hold-off request stops it for a long counted stretch, long
   // enough for the pipeline and the output queue to fill and stall the input.
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < 300; n++) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one direction pair and waits for its transfer. Valid stays high
   // between back-to-back transfers; it drops only for an idle burst or a drain.
   // Ready only changes at a rising edge, so its value at the falling edge is
   // the one the next rising edge sees.
   task automatic send_dirs(logic signed [15:0] ox, oy, oz, ix, iy, iz, bit gaps);
      if (gaps && !steady && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {iz, iy, ix, oz, oy, ox};
      while (!req_tready) @(negedge clock);
      @(negedge clock);
   endtask

   // A Q2.14 component in the legal range [-1.0, 1.0].
   function automatic logic signed [15:0] clamp_q14(real v);
      int k;
      k = $rtoi(v * 16384.0);
      if (k > 16384) k = 16384;
      if (k < -16384) k = -16384;
      return k[15:0];
   endfunction

   function automatic logic signed [15:0] any_q14();
      int k;
      k = $urandom_range(0, 32768) - 16384;
      return k[15:0];
   endfunction

   // A random direction. Most are close to unit length; some sit near the normal
   // or near the horizon, where the sine and tangent terms get extreme, and a few
   // are pure noise within the field range.
   task automatic rand_dir(output logic signed [15:0] x, y, z);
      real ct, st, phi;
      case ($urandom_range(0, 9))
         0: begin
            x = any_q14();
            y = any_q14();
            z = any_q14();
            return;
         end
         1: ct = ($urandom_range(0, 1) ? 1.0 : -1.0) * (1.0 - $urandom_range(0, 40) / 16384.0);
         2: ct = ($urandom_range(0, 1) ? 1.0 : -1.0) * $urandom_range(0, 20) / 16384.0;
         default: ct = (real'($urandom_range(0, 32768)) - 16384.0) / 16384.0;
      endcase
      st  = $sqrt(1.0 - ct * ct > 0.0 ? 1.0 - ct * ct : 0.0);
      phi = 6.283185307 * $urandom_range(0, 99999) / 100000.0;
      x   = clamp_q14(st * $cos(phi));
      y   = clamp_q14(st * $sin(phi));
      z   = clamp_q14(ct);
   endtask

   task automatic send_random(bit gaps);
      logic signed [15:0] ox, oy, oz, ix, iy, iz;
      rand_dir(ox, oy, oz);
      rand_dir(ix, iy, iz);
      send_dirs(ox, oy, oz, ix, iy, iz, gaps);
   endtask

   // One register write; the write enable then goes low before the task returns.
   task automatic write_reg(onbe_pkg::csr_reg_type idx, logic [16:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // The pipeline is empty once every expected result has been transferred;
   // registers are only changed then.
   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic load_config(logic [15:0] r, g, b, logic [16:0] a, cb);
      drain();
      write_reg(onbe_pkg::REG_ALBEDO_RED, {1'b0, r});
      write_reg(onbe_pkg::REG_ALBEDO_GREEN, {1'b0, g});
      write_reg(onbe_pkg::REG_ALBEDO_BLUE, {1'b0, b});
      write_reg(onbe_pkg::REG_COEF_A, a);
      write_reg(onbe_pkg::REG_COEF_B, cb);
   endtask

   // The directed cases: the field extremes, both directions on the normal,
   // grazing directions, equal cosines and tiny sines.
   task automatic send_directed();
      send_dirs(16384, 0, 0, 0, 16384, 0, 0);
      send_dirs(-16384, -16384, -16384, -16384, -16384, -16384, 0);
      send_dirs(16384, 16384, 16384, 16384, 16384, 16384, 0);
      send_dirs(0, 0, 16384, 0, 0, 16384, 0);
      send_dirs(0, 0, -16384, 0, 0, 16384, 0);
      send_dirs(16384, 0, 0, 16384, 0, 0, 0);
      send_dirs(-16384, 0, 0, 16384, 0, 0, 0);
      send_dirs(11585, 0, 11585, 11585, 0, 11585, 0);
      send_dirs(11585, 0, -11585, 0, 11585, 11585, 0);
      send_dirs(0, 16384, 1, 0, 16384, 8192, 0);
      send_dirs(1, 0, 16384, 0, 1, 16383, 0);
      send_dirs(1, 1, 16383, 1, 1, 16383, 0);
      send_dirs(16383, 0, 200, 16000, 3000, 2000, 0);
      send_dirs(9000, 9000, 9000, 9000, 9000, 9000, 0);
      send_dirs(-32768 + 16384, 0, 0, 0, 0, 0, 0);
      send_dirs(16384, 16384, 0, 16384, 16384, 0, 0);
      send_dirs(8192, -8192, 11585, -8192, 8192, 11585, 0);
      send_dirs(0, 0, 0, 0, 0, 0, 0);
   endtask

   // Stimulus. Each phase after the first loads a register setting, then sends
   // random items, led by the directed cases in the first two phases. Between
   // phases the sender waits until every expected result has come back.
   initial begin
      int p, i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = onbe_pkg::REG_ALBEDO_RED;
      csr_wdata  = '0;
      steady     = 1'b0;
      hold_rsp   = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      for (p = 0; p < 6; p++) begin
         case (p)
            0: ;  // reset values: A only, B zero
            1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd65536, 17'd65536);
            2: load_config(16'd0, 16'd0, 16'd0, 17'd0, 17'd0);
            3: load_config(16'd40000, 16'd1, 16'd65535, 17'd0, 17'd65536);
            default: load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)),
                                 17'($urandom_range(0, 65536)));
         endcase
         if (p == 1) begin
            // A write to an index with no register must change nothing.
            write_reg(onbe_pkg::csr_reg_type'(5), 17'h1FFFF);
            write_reg(onbe_pkg::csr_reg_type'(7), 17'd0);
         end
         if (p == 5) steady = 1'b1;
         if (p < 2) send_directed();
         if (p == 3) begin
            // Long receiver hold-off while the sender keeps offering items.
            hold_rsp = 1'b1;
            for (i = 0; i < 120; i++) send_random(0);
         end
         for (i = 0; i < 125; i++) send_random(1);
      end

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
src/onbe_pkg.sv
src/onbe_div_pipe.sv
src/oren_nayar_brdf_eval_unit.sv
verif/onbe_checker.sv
verif/tb_oren_nayar_brdf_eval_unit.sv
